### rtl/jtag_bit_command_encoder_macros.svh
// Assertion macros for the checker file of the JTAG bit command encoder.
`ifndef JTAG_BIT_COMMAND_ENCODER_MACROS_SVH
`define JTAG_BIT_COMMAND_ENCODER_MACROS_SVH

// Same-cycle implication under reset.
`define JBCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define JBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/jbce_pkg.sv
// Types, command byte constants and helpers for the JTAG bit command encoder.
package jbce_pkg;

    typedef enum logic [1:0] {
        REQ_SHIFT = 2'd0,
        REQ_FLUSH = 2'd1,
        REQ_RESET = 2'd2,
        REQ_SPEED = 2'd3
    } req_type_t;

    typedef struct packed {
        req_type_t  req_type;
        logic       tms_bit;
        logic       tdi_bit;
        logic       tdo_wanted;
        logic       reset_req;
        logic [1:0] speed_code;
    } req_t;

    typedef struct packed {
        logic [7:0] cmd_byte;
        logic       expects_reply;
        logic       last;
    } cmd_t;

    localparam int unsigned MAX_BYTES  = 4;
    localparam int unsigned NUM_SLOTS  = 5;

    localparam logic [7:0] CMD_CLK_START = 8'hA4;
    localparam logic [7:0] CMD_TDI_ONE   = 8'h0B;
    localparam logic [7:0] CMD_TDI_ZERO  = 8'h0A;
    localparam logic [7:0] CMD_BIT_LEAD  = 8'hC0;
    localparam logic [7:0] CMD_TMS_HIGH  = 8'hEC;
    localparam logic [7:0] CMD_TMS_LOW   = 8'hE8;
    localparam logic [7:0] CMD_BIT_READ  = 8'hD4;
    localparam logic [7:0] CMD_BIT_WRITE = 8'hC4;
    localparam logic [7:0] CMD_CLK_LOW   = 8'hCA;
    localparam logic [7:0] CMD_IDLE      = 8'hA0;
    localparam logic [7:0] CMD_SPEED     = 8'hA8;
    localparam logic [7:0] CMD_RST_TMS   = 8'h04;
    localparam logic [7:0] CMD_RST_ASSERT = 8'h02;
    localparam logic [7:0] CMD_PACKED    = 8'h30;

    // The adapter answers read-type bytes with one reply byte.
    function automatic logic wants_reply(input logic [7:0] b);
        return ((b & 8'hC0) == 8'h40) || ((b & 8'hD0) == 8'hD0);
    endfunction

endpackage

### rtl/jtag_bit_command_encoder.sv
// Each request is held in the input register and its bytes leave through the result register.
// Throughput: one request per cycle when it yields at most one byte and the output is not
// stalled; a longer request holds the input register until its last byte is taken (one byte per cycle unless stalled).
// Reset (rst_n low, asynchronous) clears clock, TMS and pending-bit state and
// empties both the request and result registers.
module jtag_bit_command_encoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  jbce_pkg::req_t  req,
    output logic            cmd_valid,
    input  logic            cmd_stall,
    output jbce_pkg::cmd_t  cmd
);

    jbce_pkg::req_t in_reg;
    logic           in_valid_reg;
    logic           in_valid_next;
    logic [1:0]     idx_reg;
    logic [1:0]     idx_next;

    logic           clock_active_reg, clock_active_next;
    logic           tms_level_reg, tms_level_next;
    logic [3:0]     pending_bits_reg, pending_bits_next;
    logic [1:0]     pending_count_reg, pending_count_next;

    jbce_pkg::cmd_t cmd_reg;
    logic           cmd_valid_reg;
    logic           cmd_valid_next;

    logic [7:0]     slot_byte [jbce_pkg::NUM_SLOTS];
    logic           slot_en   [jbce_pkg::NUM_SLOTS];
    logic [7:0]     burst     [jbce_pkg::MAX_BYTES];
    logic [2:0]     burst_len;
    logic [1:0]     last_idx;
    logic [7:0]     tdi_code;
    logic [3:0]     packed_bits;
    logic           pack_only;
    logic           out_free;
    logic           step;
    logic           done;
    logic           take;

    // Build the candidate byte sequence and the state after this request.
    always_comb
    begin
        for (int i = 0; i < jbce_pkg::NUM_SLOTS; i++)
        begin
            slot_byte[i] = 8'h00;
            slot_en[i]   = 1'b0;
        end
        clock_active_next  = clock_active_reg;
        tms_level_next     = tms_level_reg;
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;

        tdi_code  = in_reg.tdi_bit ? jbce_pkg::CMD_TDI_ONE : jbce_pkg::CMD_TDI_ZERO;
        pack_only = clock_active_reg && !in_reg.tdo_wanted
                    && (in_reg.tms_bit == tms_level_reg);
        packed_bits = (pending_count_reg == 2'd0) ? {3'b000, in_reg.tdi_bit}
                      : (pending_bits_reg | ({3'b000, in_reg.tdi_bit} << pending_count_reg));

        unique case (in_reg.req_type)
            jbce_pkg::REQ_SHIFT:
            begin
                if (pack_only)
                begin
                    pending_bits_next = packed_bits;
                    if (pending_count_reg == 2'd3)
                    begin
                        slot_byte[0]       = jbce_pkg::CMD_PACKED | {4'h0, packed_bits};
                        slot_en[0]         = 1'b1;
                        pending_count_next = 2'd0;
                    end
                    else
                    begin
                        pending_count_next = pending_count_reg + 2'd1;
                    end
                end
                else
                begin
                    slot_byte[0] = jbce_pkg::CMD_CLK_START;
                    slot_en[0]   = !clock_active_reg;
                    slot_byte[1] = {2'b00, pending_count_reg - 2'd1, pending_bits_reg};
                    slot_en[1]   = (pending_count_reg != 2'd0);
                    slot_byte[2] = jbce_pkg::CMD_BIT_LEAD | tdi_code;
                    slot_en[2]   = 1'b1;
                    slot_byte[3] = in_reg.tms_bit ? jbce_pkg::CMD_TMS_HIGH
                                                  : jbce_pkg::CMD_TMS_LOW;
                    slot_en[3]   = (in_reg.tms_bit != tms_level_reg);
                    slot_byte[4] = (in_reg.tdo_wanted ? jbce_pkg::CMD_BIT_READ
                                                      : jbce_pkg::CMD_BIT_WRITE) | tdi_code;
                    slot_en[4]   = 1'b1;
                    clock_active_next  = 1'b1;
                    tms_level_next     = in_reg.tms_bit;
                    pending_count_next = 2'd0;
                end
            end
            jbce_pkg::REQ_FLUSH:
            begin
                slot_byte[1] = {2'b00, pending_count_reg - 2'd1, pending_bits_reg};
                slot_en[1]   = (pending_count_reg != 2'd0);
                slot_byte[2] = jbce_pkg::CMD_CLK_LOW;
                slot_en[2]   = 1'b1;
                slot_byte[3] = jbce_pkg::CMD_IDLE;
                slot_en[3]   = 1'b1;
                clock_active_next  = 1'b0;
                pending_count_next = 2'd0;
            end
            jbce_pkg::REQ_RESET:
            begin
                slot_byte[0] = jbce_pkg::CMD_TMS_LOW
                               | (tms_level_reg ? jbce_pkg::CMD_RST_TMS : 8'h00)
                               | (in_reg.reset_req ? jbce_pkg::CMD_RST_ASSERT : 8'h00);
                slot_en[0]   = 1'b1;
            end
            jbce_pkg::REQ_SPEED:
            begin
                slot_byte[0] = jbce_pkg::CMD_SPEED | {6'b000000, in_reg.speed_code};
                slot_en[0]   = 1'b1;
            end
            default:
            begin
                slot_en[0] = 1'b0;
            end
        endcase
    end

    // Compact enabled slots into the burst, keeping at most four bytes.
    always_comb
    begin
        for (int k = 0; k < jbce_pkg::MAX_BYTES; k++)
        begin
            burst[k] = 8'h00;
        end
        burst_len = 3'd0;
        for (int i = 0; i < jbce_pkg::NUM_SLOTS; i++)
        begin
            if (slot_en[i] && (burst_len < 3'd4))
            begin
                burst[burst_len[1:0]] = slot_byte[i];
                burst_len = burst_len + 3'd1;
            end
        end
    end

    always_comb
    begin
        last_idx  = 2'(burst_len - 3'd1);
        out_free  = !cmd_valid_reg || !cmd_stall;
        step      = in_valid_reg && ((burst_len == 3'd0) || out_free);
        done      = step && ((burst_len == 3'd0) || (idx_reg == last_idx));
        req_stall = in_valid_reg && !done;
        take      = req_valid && !req_stall;

        in_valid_next = take ? 1'b1 : (done ? 1'b0 : in_valid_reg);
        idx_next      = done ? 2'd0 : (step ? idx_reg + 2'd1 : idx_reg);

        if (step && (burst_len != 3'd0))
        begin
            cmd_valid_next = 1'b1;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg && cmd_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            idx_reg           <= 2'd0;
            cmd_valid_reg     <= 1'b0;
            clock_active_reg  <= 1'b0;
            tms_level_reg     <= 1'b0;
            pending_bits_reg  <= 4'h0;
            pending_count_reg <= 2'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            idx_reg       <= idx_next;
            cmd_valid_reg <= cmd_valid_next;
            // commit state once the last byte of a request has moved out
            if (done)
            begin
                clock_active_reg  <= clock_active_next;
                tms_level_reg     <= tms_level_next;
                pending_bits_reg  <= pending_bits_next;
                pending_count_reg <= pending_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= req;
        end
        if (step && (burst_len != 3'd0))
        begin
            cmd_reg.cmd_byte      <= burst[idx_reg];
            cmd_reg.expects_reply <= jbce_pkg::wants_reply(burst[idx_reg]);
            cmd_reg.last          <= (idx_reg == last_idx);
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

### rtl/jbce_checker.sv
// Port-level checker for the JTAG bit command encoder, with its bind.
`include "jtag_bit_command_encoder_macros.svh"

module jbce_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_stall,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input jbce_pkg::cmd_t cmd
);

    // a stalled result stays offered
    `JBCE_ASSERT_NEXT(a_cmd_hold, clk, rst_n, cmd_valid && cmd_stall, cmd_valid,
        "cmd dropped while stalled")

    // bytes of one request follow without a gap
    `JBCE_ASSERT_NEXT(a_burst_gapless, clk, rst_n, cmd_valid && !cmd_stall && !cmd.last,
        cmd_valid, "gap inside a command burst")

    // reply flag follows the byte code
    `JBCE_ASSERT_NOW(a_reply_flag, clk, rst_n, cmd_valid,
        cmd.expects_reply == (((cmd.cmd_byte & 8'hC0) == 8'h40)
        || ((cmd.cmd_byte & 8'hD0) == 8'hD0)), "reply flag mismatch")

    // a request is never stalled straight after reset
    `JBCE_ASSERT_NOW(a_no_stall_idle, clk, rst_n, !$past(rst_n), !req_stall,
        "stall right after reset")

endmodule

bind jtag_bit_command_encoder jbce_checker u_jbce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
);

### dv/jtag_bit_command_encoder_tb.sv
// Self-checking testbench for the JTAG bit command encoder.
module jtag_bit_command_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    logic clk;
    logic rst_n = 1'b0;

    logic           req_valid = 1'b0;
    logic           req_stall;
    jbce_pkg::req_t req       = '0;
    logic           cmd_valid;
    logic           cmd_stall = 1'b0;
    jbce_pkg::cmd_t cmd;

    jtag_bit_command_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    jbce_pkg::req_t req_pending_q [$];
    jbce_pkg::cmd_t cmd_expect_q [$];
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   mismatch_count = 0;
    int   cycle_count   = 0;
    logic stim_tms      = 1'b0;

    // Encoder state as the predictor sees it
    logic       clk_running = 1'b0;
    logic       tms_state   = 1'b0;
    logic [3:0] nibble_bits = 4'd0;
    logic [1:0] nibble_count = 2'd0;
    logic [7:0] pred_bytes [$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_pending_nibble();
        if (nibble_count != 2'd0)
        begin
            pred_bytes.push_back({2'b00, nibble_count - 2'd1, nibble_bits});
            nibble_count = 2'd0;
        end
    endtask

    task automatic predict_commands(input jbce_pkg::req_t r);
        logic [7:0]     tdi_code;
        logic [7:0]     b;
        logic           clocked;
        jbce_pkg::cmd_t c;
        int             n;
        pred_bytes.delete();
        case (r.req_type)
            jbce_pkg::REQ_SHIFT:
            begin
                clocked = 1'b1;
                if (!clk_running)
                begin
                    pred_bytes.push_back(jbce_pkg::CMD_CLK_START);
                    clk_running = 1'b1;
                end
                else if (!r.tdo_wanted && r.tms_bit == tms_state)
                begin
                    // pack the bit; a full nibble goes out as one byte
                    clocked = 1'b0;
                    if (nibble_count == 2'd0)
                        nibble_bits = {3'b000, r.tdi_bit};
                    else
                        nibble_bits = nibble_bits | ({3'b000, r.tdi_bit} << nibble_count);
                    if (nibble_count == 2'd3)
                    begin
                        pred_bytes.push_back(jbce_pkg::CMD_PACKED | {4'd0, nibble_bits});
                        nibble_count = 2'd0;
                    end
                    else
                    begin
                        nibble_count = nibble_count + 2'd1;
                    end
                end
                if (clocked)
                begin
                    send_pending_nibble();
                    tdi_code = r.tdi_bit ? jbce_pkg::CMD_TDI_ONE : jbce_pkg::CMD_TDI_ZERO;
                    pred_bytes.push_back(jbce_pkg::CMD_BIT_LEAD | tdi_code);
                    if (r.tms_bit != tms_state)
                    begin
                        pred_bytes.push_back(r.tms_bit ? jbce_pkg::CMD_TMS_HIGH
                                                       : jbce_pkg::CMD_TMS_LOW);
                        tms_state = r.tms_bit;
                    end
                    pred_bytes.push_back((r.tdo_wanted ? jbce_pkg::CMD_BIT_READ
                                                       : jbce_pkg::CMD_BIT_WRITE)
                                         | tdi_code);
                end
            end
            jbce_pkg::REQ_FLUSH:
            begin
                send_pending_nibble();
                pred_bytes.push_back(jbce_pkg::CMD_CLK_LOW);
                clk_running = 1'b0;
                pred_bytes.push_back(jbce_pkg::CMD_IDLE);
            end
            jbce_pkg::REQ_RESET:
            begin
                b = jbce_pkg::CMD_TMS_LOW;
                if (tms_state)
                    b = b | jbce_pkg::CMD_RST_TMS;
                if (r.reset_req)
                    b = b | jbce_pkg::CMD_RST_ASSERT;
                pred_bytes.push_back(b);
            end
            default:
            begin
                pred_bytes.push_back(jbce_pkg::CMD_SPEED | {6'd0, r.speed_code});
            end
        endcase
        n = (pred_bytes.size() > jbce_pkg::MAX_BYTES) ? jbce_pkg::MAX_BYTES
                                                      : pred_bytes.size();
        for (int k = 0; k < n; k++)
        begin
            b = pred_bytes[k];
            c.cmd_byte      = b;
            c.expects_reply = ((b & 8'hC0) == 8'h40) || ((b & 8'hD0) == 8'hD0);
            c.last          = (k == n - 1);
            cmd_expect_q.push_back(c);
        end
    endtask

    task automatic log_mismatch(input string what, input jbce_pkg::cmd_t want,
                                input jbce_pkg::cmd_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected byte %02h reply %0b last %0b, got %02h %0b %0b",
                     $time, what, want.cmd_byte, want.expects_reply, want.last,
                     got.cmd_byte, got.expects_reply, got.last);
    endtask

    // Queue a request and keep track of the TMS level the stream will leave behind
    task automatic add_request(input jbce_pkg::req_type_t kind, input logic tms,
                               input logic tdi, input logic tdo, input logic rst,
                               input logic [1:0] spd);
        jbce_pkg::req_t r;
        r.req_type   = kind;
        r.tms_bit    = tms;
        r.tdi_bit    = tdi;
        r.tdo_wanted = tdo;
        r.reset_req  = rst;
        r.speed_code = spd;
        if (kind == jbce_pkg::REQ_SHIFT)
            stim_tms = tms;
        req_pending_q.push_back(r);
    endtask

    task automatic add_random_request();
        int                  roll;
        jbce_pkg::req_type_t kind;
        logic                tms;
        roll = $urandom_range(99);
        if (roll < 72)
            kind = jbce_pkg::REQ_SHIFT;
        else if (roll < 82)
            kind = jbce_pkg::REQ_FLUSH;
        else if (roll < 91)
            kind = jbce_pkg::REQ_RESET;
        else
            kind = jbce_pkg::REQ_SPEED;
        tms = stim_tms;
        if ($urandom_range(99) < 15)
            tms = ~tms;
        if (kind != jbce_pkg::REQ_SHIFT)
            tms = 1'($urandom_range(1));
        add_request(kind, tms, 1'($urandom_range(1)), ($urandom_range(99) < 15),
                    1'($urandom_range(1)), 2'($urandom_range(3)));
    endtask

    // Request driver: hold a stalled transfer, otherwise present the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_commands(req);
            if (!req_valid || !req_stall)
            begin
                if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= req_pending_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Command monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin : cmd_monitor
        jbce_pkg::cmd_t want;
        if (!rst_n)
        begin
            cmd_stall <= 1'b0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                if (cmd_expect_q.size() == 0)
                begin
                    log_mismatch("unexpected byte", '0, cmd);
                end
                else
                begin
                    want = cmd_expect_q.pop_front();
                    if (cmd.cmd_byte !== want.cmd_byte
                        || cmd.expects_reply !== want.expects_reply
                        || cmd.last !== want.last)
                        log_mismatch("byte mismatch", want, cmd);
                end
            end
            cmd_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int sender_idle [4];
        int receiver_stall [4];
        sender_idle    = '{0, 55, 0, 35};
        receiver_stall = '{0, 0, 55, 35};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // speed extremes and reset with TMS low
        add_request(jbce_pkg::REQ_SPEED, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_SPEED, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3);
        add_request(jbce_pkg::REQ_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_RESET, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3);
        // clock start, then four packed bits
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b1, 1'b0, 1'b1, 2'd1);
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b0, 1'b0, 1'b0, 2'd2);
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b1, 1'b0, 1'b0, 2'd3);
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
        // two pending bits, then a TDO capture with TMS rising: four bytes
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b1, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_SHIFT, 1'b1, 1'b0, 1'b1, 1'b0, 2'd0);
        // reset with TMS high
        add_request(jbce_pkg::REQ_RESET, 1'b0, 1'b0, 1'b0, 1'b1, 2'd0);
        add_request(jbce_pkg::REQ_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        // three pending bits flushed
        add_request(jbce_pkg::REQ_SHIFT, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_SHIFT, 1'b1, 1'b0, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_SHIFT, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0);
        add_request(jbce_pkg::REQ_FLUSH, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);
        // flush with the clock stopped and nothing pending
        add_request(jbce_pkg::REQ_FLUSH, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3);
        // clock start with TMS falling and TDO wanted: four bytes
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0);
        // capture with TMS unchanged, then TMS change without capture
        add_request(jbce_pkg::REQ_SHIFT, 1'b0, 1'b1, 1'b1, 1'b1, 2'd2);
        add_request(jbce_pkg::REQ_SHIFT, 1'b1, 1'b1, 1'b0, 1'b0, 2'd1);
        add_request(jbce_pkg::REQ_SPEED, 1'b0, 1'b0, 1'b0, 1'b0, 2'd1);
        add_request(jbce_pkg::REQ_SPEED, 1'b0, 1'b0, 1'b0, 1'b0, 2'd2);
        add_request(jbce_pkg::REQ_FLUSH, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0);

        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            send_idle_pct = sender_idle[ph];
            stall_pct     = receiver_stall[ph];
            for (int k = 0; k < RANDOM_ITEMS; k++)
                add_random_request();
            // hold the sender until every expected byte is out
            while (req_pending_q.size() != 0 || req_valid || cmd_expect_q.size() != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && cmd_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/jbce_pkg.sv
rtl/jtag_bit_command_encoder.sv
rtl/jbce_checker.sv
dv/jtag_bit_command_encoder_tb.sv
